// File: rtl/core/sfr_f8_pkg.sv
// Shared types and constants for the sync frame receiver with Fletcher-8 check.
package sfr_f8_pkg;

    localparam int BUFFER_BYTES_DEF = 256;

    localparam int POS_LEN_START = 4;
    localparam int POS_HDR_END   = 6;
    localparam int FRAME_EXTRA   = 8;

    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 8;

    typedef enum logic [0:0] {
        CFG_FIRST_SYNC  = 1'b0,
        CFG_SECOND_SYNC = 1'b1
    } cfg_index_t;

    typedef enum logic [2:0] {
        PH_SYNC1  = 3'd0,
        PH_SYNC2  = 3'd1,
        PH_HEADER = 3'd2,
        PH_LENGTH = 3'd3,
        PH_BODY   = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        EV_NONE     = 2'd0,
        EV_ACCEPTED = 2'd1,
        EV_CK_ERROR = 2'd2,
        EV_OVERLONG = 2'd3
    } frame_event_t;

    typedef struct packed {
        logic [7:0] rx_byte;
    } in_word_t;

    typedef struct packed {
        logic [1:0]  frame_event;
        logic        payload_valid;
        logic [7:0]  payload_byte;
        logic [7:0]  payload_index;
        logic [7:0]  frame_class;
        logic [7:0]  frame_id;
        logic [15:0] frame_payload_len;
        logic [7:0]  sum_a;
        logic [7:0]  sum_b;
    } out_word_t;

endpackage

// File: rtl/core/sfr_f8_stream_if.sv
// Valid/ready word channel with a typed payload.
interface sfr_f8_stream_if #(
    parameter type payload_t = logic [7:0]
) ();
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/core/sync_frame_receiver_fletcher8_top.sv
// Sync frame receiver: header parse, payload pass-through and Fletcher-8 check.
//
//  channel  | dir | handshake     | word
//  ---------+-----+---------------+------------------------------------------
//  rx       | in  | valid/ready   | rx_byte
//  result   | out | valid/ready   | frame_event, payload, header, sums
//  cfg      | in  | cfg_we        | cfg_index selects sync byte, cfg_data
//
//  One word per cycle while the output is not stalled: the parser state updates
//  in the cycle a byte is taken and the result goes into a single output register.
//  rx.ready is high while the output register is empty or being drained.
//  rst_n clears the parser to wait for the first sync byte and empties the
//  output register; the sync bytes return to 0xB5 and 0x62.
module sync_frame_receiver_fletcher8_top #(
    parameter int BUFFER_BYTES = sfr_f8_pkg::BUFFER_BYTES_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [sfr_f8_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [sfr_f8_pkg::CFG_DATA_W-1:0]   cfg_data,
    sfr_f8_stream_if.sink                       rx,
    sfr_f8_stream_if.source                     result
);
    import sfr_f8_pkg::*;

    localparam int CNT_W = $clog2(BUFFER_BYTES + 1);
    localparam int CMP_W = ((CNT_W > 17) ? CNT_W : 17) + 1;

    logic [7:0]      sync1_reg, sync2_reg;
    phase_t          phase_reg, phase_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [15:0]     len_reg, len_next;
    logic [7:0]      class_reg, class_next;
    logic [7:0]      id_reg, id_next;
    logic [7:0]      len_lo_reg, len_lo_next;
    logic [7:0]      sum_a_reg, sum_a_next;
    logic [7:0]      sum_b_reg, sum_b_next;
    logic [7:0]      ck_a_reg, ck_a_next;
    logic            out_valid_reg;
    out_word_t       out_word_reg, out_word_next;

    logic             accept;
    logic [7:0]       b;
    logic             overlong;
    phase_t           phase_eff;
    logic [CNT_W-1:0] pos;
    logic [CNT_W-1:0] pos_inc;
    logic [CMP_W-1:0] pos_ext;
    logic [CMP_W-1:0] body_end;
    logic [7:0]       add_a;
    logic [7:0]       add_b;

    assign rx.ready = !out_valid_reg || result.ready;
    assign accept   = rx.valid && rx.ready;
    assign b        = rx.data.rx_byte;

    assign overlong  = (count_reg >= CNT_W'(BUFFER_BYTES));
    assign phase_eff = overlong ? PH_SYNC1 : phase_reg;
    assign pos       = overlong ? '0 : count_reg;
    assign pos_inc   = pos + CNT_W'(1);
    assign pos_ext   = CMP_W'(pos);
    assign body_end  = CMP_W'(POS_HDR_END) + CMP_W'(len_reg);
    assign add_a     = sum_a_reg + b;
    assign add_b     = sum_b_reg + add_a;

    // next parser state
    always_comb
    begin
        phase_next  = phase_eff;
        count_next  = pos;
        len_next    = len_reg;
        class_next  = class_reg;
        id_next     = id_reg;
        len_lo_next = len_lo_reg;
        sum_a_next  = sum_a_reg;
        sum_b_next  = sum_b_reg;
        ck_a_next   = ck_a_reg;
        unique case (phase_eff)
            PH_SYNC1:
            begin
                if (b == sync1_reg)
                begin
                    count_next = CNT_W'(1);
                    phase_next = PH_SYNC2;
                end
                else
                begin
                    count_next = '0;
                end
            end
            PH_SYNC2:
            begin
                if (b == sync2_reg)
                begin
                    count_next = CNT_W'(2);
                    phase_next = PH_HEADER;
                    sum_a_next = '0;
                    sum_b_next = '0;
                end
                else
                begin
                    count_next = '0;
                    phase_next = PH_SYNC1;
                end
            end
            PH_HEADER:
            begin
                sum_a_next = add_a;
                sum_b_next = add_b;
                if (pos == CNT_W'(2))
                    class_next = b;
                else
                    id_next = b;
                count_next = pos_inc;
                if (pos_inc >= CNT_W'(POS_LEN_START))
                    phase_next = PH_LENGTH;
            end
            PH_LENGTH:
            begin
                sum_a_next = add_a;
                sum_b_next = add_b;
                if (pos == CNT_W'(POS_LEN_START))
                    len_lo_next = b;
                else
                    len_next = {b, len_lo_reg};
                count_next = pos_inc;
                if (pos_inc >= CNT_W'(POS_HDR_END))
                    phase_next = PH_BODY;
            end
            default:
            begin
                priority if (pos_ext < body_end)
                begin
                    sum_a_next = add_a;
                    sum_b_next = add_b;
                    count_next = pos_inc;
                end
                else if (pos_ext == body_end)
                begin
                    ck_a_next  = b;
                    count_next = pos_inc;
                end
                else
                begin
                    count_next = '0;
                    phase_next = PH_SYNC1;
                end
            end
        endcase
    end

    // result word
    always_comb
    begin
        out_word_next                   = '0;
        out_word_next.frame_event       = overlong ? EV_OVERLONG : EV_NONE;
        out_word_next.frame_class       = class_next;
        out_word_next.frame_id          = id_next;
        out_word_next.frame_payload_len = len_next;
        out_word_next.sum_a             = sum_a_next;
        out_word_next.sum_b             = sum_b_next;
        if (phase_eff == PH_BODY)
        begin
            priority if (pos_ext < body_end)
            begin
                out_word_next.payload_valid = 1'b1;
                out_word_next.payload_byte  = b;
                out_word_next.payload_index = pos_ext[7:0] - 8'(POS_HDR_END);
            end
            else if (pos_ext == body_end)
            begin
                out_word_next.payload_valid = 1'b0;
            end
            else
            begin
                out_word_next.frame_event = ((ck_a_reg == sum_a_reg) && (b == sum_b_reg))
                                            ? EV_ACCEPTED : EV_CK_ERROR;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync1_reg  <= 8'd181;
            sync2_reg  <= 8'd98;
            phase_reg  <= PH_SYNC1;
            count_reg  <= '0;
            len_reg    <= '0;
            class_reg  <= '0;
            id_reg     <= '0;
            len_lo_reg <= '0;
            sum_a_reg  <= '0;
            sum_b_reg  <= '0;
            ck_a_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index_t'(cfg_index))
                    CFG_FIRST_SYNC:  sync1_reg <= cfg_data;
                    CFG_SECOND_SYNC: sync2_reg <= cfg_data;
                    default:         sync1_reg <= sync1_reg;
                endcase
            end
            if (accept)
            begin
                phase_reg  <= phase_next;
                count_reg  <= count_next;
                len_reg    <= len_next;
                class_reg  <= class_next;
                id_reg     <= id_next;
                len_lo_reg <= len_lo_next;
                sum_a_reg  <= sum_a_next;
                sum_b_reg  <= sum_b_next;
                ck_a_reg   <= ck_a_next;
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            out_word_reg <= out_word_next;
    end

    assign result.valid = out_valid_reg;
    assign result.data  = out_word_reg;

endmodule

// File: tb/sv/sync_frame_receiver_fletcher8_top_tb.sv
// Self-checking testbench for the sync frame receiver: stimulus, prediction, compare.
import sfr_f8_pkg::*;

class frame_parse_board;
    logic [7:0]  sync_first;
    logic [7:0]  sync_second;
    phase_t      phase;
    int unsigned count;
    logic [15:0] decl_len;
    logic [7:0]  cls;
    logic [7:0]  id;
    logic [7:0]  len_lo;
    logic [7:0]  acc_a;
    logic [7:0]  acc_b;
    logic [7:0]  ck_first;
    out_word_t   parsed_words[$];
    int unsigned errors;

    function new();
        sync_first  = 8'hB5;
        sync_second = 8'h62;
        phase       = PH_SYNC1;
        count       = 0;
        decl_len    = '0;
        cls         = '0;
        id          = '0;
        len_lo      = '0;
        acc_a       = '0;
        acc_b       = '0;
        ck_first    = '0;
        errors      = 0;
    endfunction

    function void set_syncs(logic [7:0] first_val, logic [7:0] second_val);
        sync_first  = first_val;
        sync_second = second_val;
    endfunction

    function int unsigned pending();
        return parsed_words.size();
    endfunction

    function void fold(logic [7:0] b);
        acc_a = acc_a + b;
        acc_b = acc_b + acc_a;
    endfunction

    function void take_byte(logic [7:0] b);
        out_word_t   w;
        int unsigned pos;
        w = '0;
        if (count >= BUFFER_BYTES_DEF) begin
            w.frame_event = EV_OVERLONG;
            phase = PH_SYNC1;
            count = 0;
        end
        pos = count;
        case (phase)
            PH_SYNC1:
            begin
                if (b == sync_first) begin
                    count = 1;
                    phase = PH_SYNC2;
                end
            end
            PH_SYNC2:
            begin
                if (b == sync_second) begin
                    count = 2;
                    phase = PH_HEADER;
                    acc_a = '0;
                    acc_b = '0;
                end else begin
                    count = 0;
                    phase = PH_SYNC1;
                end
            end
            PH_HEADER:
            begin
                fold(b);
                if (pos == 2) cls = b;
                else id = b;
                count = pos + 1;
                if (count >= POS_LEN_START) phase = PH_LENGTH;
            end
            PH_LENGTH:
            begin
                fold(b);
                if (pos == POS_LEN_START) len_lo = b;
                else decl_len = {b, len_lo};
                count = pos + 1;
                if (count >= POS_HDR_END) phase = PH_BODY;
            end
            default:
            begin
                if (pos < POS_HDR_END + int'(decl_len)) begin
                    fold(b);
                    w.payload_valid = 1'b1;
                    w.payload_byte  = b;
                    w.payload_index = 8'(pos - POS_HDR_END);
                    count = pos + 1;
                end else if (pos == POS_HDR_END + int'(decl_len)) begin
                    ck_first = b;
                    count = pos + 1;
                end else begin
                    w.frame_event = (ck_first == acc_a && b == acc_b)
                                    ? EV_ACCEPTED : EV_CK_ERROR;
                    count = 0;
                    phase = PH_SYNC1;
                end
            end
        endcase
        w.frame_class       = cls;
        w.frame_id          = id;
        w.frame_payload_len = decl_len;
        w.sum_a             = acc_a;
        w.sum_b             = acc_b;
        parsed_words.push_back(w);
    endfunction

    task report(string msg);
        errors++;
        if (errors <= 100) $display("mismatch at %0t: %s", $time, msg);
    endtask

    task match_word(out_word_t got);
        out_word_t want;
        if (parsed_words.size() == 0) begin
            report($sformatf("result word %h with nothing outstanding", got));
            return;
        end
        want = parsed_words.pop_front();
        if (got.frame_event !== want.frame_event)
            report($sformatf("frame_event %0d, want %0d", got.frame_event,
                             want.frame_event));
        if (got.payload_valid !== want.payload_valid)
            report($sformatf("payload_valid %0d, want %0d", got.payload_valid,
                             want.payload_valid));
        if (got.payload_byte !== want.payload_byte)
            report($sformatf("payload_byte %h, want %h", got.payload_byte,
                             want.payload_byte));
        if (got.payload_index !== want.payload_index)
            report($sformatf("payload_index %0d, want %0d", got.payload_index,
                             want.payload_index));
        if (got.frame_class !== want.frame_class)
            report($sformatf("frame_class %h, want %h", got.frame_class, want.frame_class));
        if (got.frame_id !== want.frame_id)
            report($sformatf("frame_id %h, want %h", got.frame_id, want.frame_id));
        if (got.frame_payload_len !== want.frame_payload_len)
            report($sformatf("frame_payload_len %0d, want %0d", got.frame_payload_len,
                             want.frame_payload_len));
        if (got.sum_a !== want.sum_a)
            report($sformatf("sum_a %h, want %h", got.sum_a, want.sum_a));
        if (got.sum_b !== want.sum_b)
            report($sformatf("sum_b %h, want %h", got.sum_b, want.sum_b));
    endtask
endclass

module sync_frame_receiver_fletcher8_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum int {
        CK_GOOD,
        CK_BAD_A,
        CK_BAD_B,
        CK_BAD_BOTH
    } ck_fault_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int unsigned burst_left = 0;
    int unsigned bytes_sent = 0;
    int unsigned hold_off = 0;
    logic [7:0]  cur_first = 8'hB5;
    logic [7:0]  cur_second = 8'h62;
    logic [7:0]  frame_buf[$];

    frame_parse_board sb;

    sfr_f8_stream_if #(.payload_t(in_word_t))  rx_if ();
    sfr_f8_stream_if #(.payload_t(out_word_t)) result_if ();

    sync_frame_receiver_fletcher8_top #(
        .BUFFER_BYTES(BUFFER_BYTES_DEF)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .rx        (rx_if),
        .result    (result_if)
    );

    always #5 clk = ~clk;

    initial
    begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && result_if.valid && result_if.ready) sb.match_word(result_if.data);
    end

    initial
    begin : receiver
        int unsigned mode;
        int unsigned left;
        int unsigned tick;
        mode = 0;
        left = 0;
        tick = 0;
        result_if.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            @(posedge clk);
            tick++;
            if (hold_off > 0) begin
                result_if.ready <= 1'b0;
                hold_off--;
            end else begin
                if (left == 0) begin
                    mode = $urandom_range(0, 3);
                    left = $urandom_range(10, 80);
                end
                left--;
                case (mode)
                    0: result_if.ready <= 1'b1;
                    1: result_if.ready <= 1'($urandom_range(0, 1));
                    2: result_if.ready <= (tick % 4) != 0;
                    default: result_if.ready <= $urandom_range(0, 7) != 0;
                endcase
            end
        end
    end

    task automatic send_byte(input logic [7:0] b);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                rx_if.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                      : $urandom_range(1, 24);
        end
        rx_if.valid <= 1'b1;
        rx_if.data  <= in_word_t'(b);
        do @(posedge clk); while (!rx_if.ready);
        sb.take_byte(b);
        bytes_sent++;
        burst_left--;
    endtask

    task automatic drain();
        rx_if.valid <= 1'b0;
        burst_left = 0;
        while (sb.pending() != 0) @(posedge clk);
    endtask

    task automatic write_syncs(input logic [7:0] first_val, input logic [7:0] second_val);
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_FIRST_SYNC;
        cfg_data  <= first_val;
        @(posedge clk);
        cfg_index <= CFG_SECOND_SYNC;
        cfg_data  <= second_val;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_syncs(first_val, second_val);
        cur_first  = first_val;
        cur_second = second_val;
    endtask

    // payload is cut short on huge lengths; the buffer limit discards those frames anyway
    function automatic void build_frame(input logic [7:0] cls, input logic [7:0] id,
                                        input logic [15:0] len, input ck_fault_t fault);
        logic [7:0]  a;
        logic [7:0]  bsum;
        int unsigned n;
        frame_buf.delete();
        frame_buf.push_back(cur_first);
        frame_buf.push_back(cur_second);
        frame_buf.push_back(cls);
        frame_buf.push_back(id);
        frame_buf.push_back(len[7:0]);
        frame_buf.push_back(len[15:8]);
        n = (len > 250) ? 250 : len;
        repeat (n) frame_buf.push_back(8'($urandom));
        a = '0;
        bsum = '0;
        for (int i = 2; i < frame_buf.size(); i++) begin
            a = a + frame_buf[i];
            bsum = bsum + a;
        end
        if (fault == CK_BAD_A || fault == CK_BAD_BOTH)
            a = a ^ 8'($urandom_range(1, 255));
        if (fault == CK_BAD_B || fault == CK_BAD_BOTH)
            bsum = bsum ^ 8'($urandom_range(1, 255));
        frame_buf.push_back(a);
        frame_buf.push_back(bsum);
    endfunction

    task automatic send_frame_bytes(input int unsigned keep);
        for (int i = 0; i < keep; i++) send_byte(frame_buf[i]);
    endtask

    task automatic send_frame(input logic [7:0] cls, input logic [7:0] id,
                              input logic [15:0] len, input ck_fault_t fault);
        build_frame(cls, id, len, fault);
        send_frame_bytes(frame_buf.size());
    endtask

    task automatic random_traffic(input int unsigned budget);
        int unsigned start;
        int unsigned sel;
        int unsigned r;
        int unsigned n;
        logic [15:0] len;
        ck_fault_t   fault;
        start = bytes_sent;
        while (bytes_sent - start < budget) begin
            sel = $urandom_range(0, 99);
            if (sel < 8) begin
                n = $urandom_range(1, 4);
                repeat (n) send_byte(8'($urandom));
            end else begin
                r = $urandom_range(0, 199);
                if (r < 170) len = 16'($urandom_range(0, 12));
                else if (r < 195) len = 16'($urandom_range(13, 60));
                else if (r < 198) len = 16'($urandom_range(240, 252));
                else len = 16'($urandom);
                r = $urandom_range(0, 9);
                fault = (r < 7) ? CK_GOOD : (r == 7) ? CK_BAD_A
                      : (r == 8) ? CK_BAD_B : CK_BAD_BOTH;
                build_frame(8'($urandom), 8'($urandom), len, fault);
                if (sel < 15) send_frame_bytes($urandom_range(1, frame_buf.size() - 1));
                else send_frame_bytes(frame_buf.size());
            end
        end
    endtask

    initial
    begin : stimulus
        sb = new();
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = CFG_FIRST_SYNC;
        cfg_data     = '0;
        rx_if.valid  = 1'b0;
        rx_if.data   = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_byte(8'h00);
        send_byte(8'hFF);
        send_frame(8'h00, 8'hFF, 16'd0, CK_GOOD);
        send_frame(8'hFF, 8'h00, 16'd3, CK_GOOD);
        send_frame(8'h01, 8'h02, 16'd5, CK_BAD_A);
        send_frame(8'h01, 8'h02, 16'd5, CK_BAD_B);
        // second sync wrong: the repeated first sync is not taken as a new start
        send_byte(cur_first);
        send_byte(cur_first);
        send_byte(cur_second);
        send_frame(8'h80, 8'h7F, 16'd2, CK_GOOD);
        send_frame(8'h11, 8'h22, 16'd248, CK_GOOD);
        // buffer full: the frame is discarded and its last check byte is parsed afresh
        send_frame(8'h33, 8'h44, 16'd249, CK_GOOD);
        send_frame(8'h55, 8'h66, 16'hFFFF, CK_GOOD);
        build_frame(8'h77, 8'h88, 16'd249, CK_GOOD);
        send_frame_bytes(frame_buf.size() - 1);
        send_frame(8'h99, 8'hAA, 16'd1, CK_GOOD);
        build_frame(8'hBB, 8'hCC, 16'd4, CK_GOOD);
        send_frame_bytes(4);
        send_frame(8'hDD, 8'hEE, 16'd0, CK_GOOD);

        hold_off = 80;
        random_traffic(120);

        write_syncs(8'h00, 8'hFF);
        random_traffic(60);
        drain();
        random_traffic(60);

        write_syncs(8'hFF, 8'h00);
        random_traffic(120);

        write_syncs(8'h55, 8'h55);
        hold_off = 120;
        random_traffic(120);

        write_syncs(8'($urandom), 8'($urandom));
        random_traffic(120);

        drain();
        repeat (4) @(posedge clk);
        if (sb.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule

// File: files.f
rtl/core/sfr_f8_pkg.sv
rtl/core/sfr_f8_stream_if.sv
rtl/core/sync_frame_receiver_fletcher8_top.sv
tb/sv/sync_frame_receiver_fletcher8_top_tb.sv
